>>> rtl/scc_pkg.sv
// shared types, op codes and constants for the scc source component counter
package scc_pkg;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int OPW = 5;

    localparam logic [OPW-1:0] OP_CLR    = 5'd0;
    localparam logic [OPW-1:0] OP_IDLE   = 5'd1;
    localparam logic [OPW-1:0] OP_LDRD   = 5'd2;
    localparam logic [OPW-1:0] OP_LDWR   = 5'd3;
    localparam logic [OPW-1:0] OP_ROOT   = 5'd4;
    localparam logic [OPW-1:0] OP_ROOT2  = 5'd5;
    localparam logic [OPW-1:0] OP_ENTER  = 5'd6;
    localparam logic [OPW-1:0] OP_ENTER2 = 5'd7;
    localparam logic [OPW-1:0] OP_LOOP   = 5'd8;
    localparam logic [OPW-1:0] OP_EDGE   = 5'd9;
    localparam logic [OPW-1:0] OP_EDGE2  = 5'd10;
    localparam logic [OPW-1:0] OP_POP    = 5'd11;
    localparam logic [OPW-1:0] OP_SCC1   = 5'd12;
    localparam logic [OPW-1:0] OP_SCC2   = 5'd13;
    localparam logic [OPW-1:0] OP_RET1   = 5'd14;
    localparam logic [OPW-1:0] OP_RET2   = 5'd15;
    localparam logic [OPW-1:0] OP_RET3   = 5'd16;
    localparam logic [OPW-1:0] OP_M0     = 5'd17;
    localparam logic [OPW-1:0] OP_M1     = 5'd18;
    localparam logic [OPW-1:0] OP_M2     = 5'd19;
    localparam logic [OPW-1:0] OP_M3     = 5'd20;
    localparam logic [OPW-1:0] OP_M4     = 5'd21;
    localparam logic [OPW-1:0] OP_C0     = 5'd22;
    localparam logic [OPW-1:0] OP_C1     = 5'd23;
    localparam logic [OPW-1:0] OP_DONE   = 5'd24;

    typedef struct packed {
        logic       kind;
        logic [9:0] edge_from;
        logic [9:0] edge_to;
    } t_in;

    typedef struct packed {
        logic [10:0] source_components;
        logic [10:0] component_count;
        logic        error;
    } t_out;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           accept;
    } t_cmd;

    typedef struct packed {
        logic clr_end;
        logic out_busy;
        logic edge_ok;
        logic root_end;
        logic vis_zero;
        logic cur_none;
        logic j_out;
        logic is_root_scc;
        logic scc_more;
        logic fp_zero;
        logic i_end;
        logic e_none;
        logic k_in;
        logic cnt_end;
    } t_stat;

endpackage

>>> rtl/scc_ctrl.sv
// sequencer for edge loading, component search, marking and clearing
module scc_ctrl import scc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_kind,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    logic [OPW-1:0] r_state;
    logic [OPW-1:0] n_state;
    logic           accept;

    assign o_in_ready = (r_state == OP_IDLE);
    assign accept     = o_in_ready && i_in_valid;
    assign o_cmd.op     = r_state;
    assign o_cmd.accept = accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            OP_CLR:    n_state = i_stat.clr_end ? OP_IDLE : OP_CLR;
            OP_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_FINISH) n_state = OP_ROOT;
                    else if (i_stat.edge_ok)   n_state = OP_LDRD;
                end
            end
            OP_LDRD:   n_state = OP_LDWR;
            OP_LDWR:   n_state = OP_IDLE;
            OP_ROOT:   n_state = i_stat.root_end ? OP_M0 : OP_ROOT2;
            OP_ROOT2:  n_state = i_stat.vis_zero ? OP_ENTER : OP_ROOT;
            OP_ENTER:  n_state = OP_ENTER2;
            OP_ENTER2: n_state = OP_LOOP;
            OP_LOOP:   n_state = i_stat.cur_none ? OP_POP : OP_EDGE;
            OP_EDGE:   n_state = i_stat.j_out ? OP_LOOP : OP_EDGE2;
            OP_EDGE2:  n_state = i_stat.vis_zero ? OP_ENTER : OP_LOOP;
            OP_POP:    n_state = i_stat.is_root_scc ? OP_SCC1 : OP_RET1;
            OP_SCC1:   n_state = OP_SCC2;
            OP_SCC2:   n_state = i_stat.scc_more ? OP_SCC1 : OP_RET1;
            OP_RET1:   n_state = i_stat.fp_zero ? OP_ROOT : OP_RET2;
            OP_RET2:   n_state = OP_RET3;
            OP_RET3:   n_state = OP_LOOP;
            OP_M0:     n_state = i_stat.i_end ? OP_C0 : OP_M1;
            OP_M1:     n_state = OP_M2;
            OP_M2:     n_state = i_stat.e_none ? OP_M0 : OP_M3;
            OP_M3:     n_state = i_stat.k_in ? OP_M4 : OP_M2;
            OP_M4:     n_state = OP_M2;
            OP_C0:     n_state = i_stat.cnt_end ? OP_DONE : OP_C1;
            OP_C1:     n_state = OP_C0;
            OP_DONE:   n_state = i_stat.out_busy ? OP_DONE : OP_CLR;
            default:   n_state = OP_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/scc_dp.sv
// graph stores, search registers and result register
module scc_dp import scc_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  t_in                            i_in,
    input  logic [$clog2(MAX_NODES+1)-1:0] i_n,
    output t_stat                          o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output t_out                           o_out
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    logic [EW-1:0] head_mem  [MAX_NODES];
    logic [NW-1:0] etgt_mem  [MAX_EDGES];
    logic [EW-1:0] enext_mem [MAX_EDGES];
    logic [CW-1:0] vis_mem   [MAX_NODES];
    logic [CW-1:0] low_mem   [MAX_NODES];
    logic [NW-1:0] cstk_mem  [MAX_NODES];
    logic          onst_mem  [MAX_NODES];
    logic [CW-1:0] comp_mem  [MAX_NODES];
    logic          hasin_mem [MAX_NODES];
    logic [NW-1:0] fnode_mem [MAX_NODES];
    logic [EW-1:0] fcur_mem  [MAX_NODES];

    logic [EW-1:0] head_rd;
    logic [NW-1:0] etgt_rd;
    logic [EW-1:0] enext_rd;
    logic [CW-1:0] vis_rd;
    logic [CW-1:0] low_rd;
    logic [NW-1:0] cstk_rd;
    logic          onst_rd;
    logic [CW-1:0] comp_rd;
    logic          hasin_rd;
    logic [NW-1:0] fnode_rd;
    logic [EW-1:0] fcur_rd;

    logic [NW-1:0] r_clr;
    logic [EW-1:0] r_et;
    logic [CW-1:0] r_clk;
    logic [CW-1:0] r_sp;
    logic [CW-1:0] r_fp;
    logic [CW-1:0] r_comps;
    logic          r_drop;
    logic          r_ovalid;
    logic [NW-1:0] r_a;
    logic [NW-1:0] r_b;
    logic [CW-1:0] r_root;
    logic [NW-1:0] r_j;
    logic [NW-1:0] r_u;
    logic [EW-1:0] r_cur;
    logic [CW-1:0] r_lowu;
    logic [CW-1:0] r_visu;
    logic [CW-1:0] r_lowc;
    logic [CW-1:0] r_i;
    logic [EW-1:0] r_e;
    logic [CW-1:0] r_ci;
    logic [CW-1:0] r_src;
    t_out          r_out;

    logic [OPW-1:0] op;
    logic [NW-1:0]  head_ra;
    logic [NW-1:0]  vis_ra;
    logic [NW-1:0]  comp_ra;
    logic [EAW-1:0] edge_ra;
    logic [NW-1:0]  fp_top;
    logic [NW-1:0]  sp_top;
    logic [CW-1:0]  clk_next;
    logic [EW-1:0]  no_edge;

    assign op       = i_cmd.op;
    assign no_edge  = EW'(MAX_EDGES);
    assign clk_next = CW'(r_clk + 1'b1);
    assign fp_top   = NW'(r_fp - 1'b1);
    assign sp_top   = NW'(r_sp - 1'b1);

    assign head_ra = (op == OP_LDRD) ? r_a : (op == OP_ENTER) ? r_j : NW'(r_i);
    assign vis_ra  = (op == OP_ROOT) ? NW'(r_root) : (op == OP_EDGE) ? etgt_rd : fnode_rd;
    assign comp_ra = (op == OP_M0) ? NW'(r_i) : etgt_rd;
    assign edge_ra = (op == OP_LOOP) ? r_cur[EAW-1:0] : r_e[EAW-1:0];

    // status back to the sequencer
    assign o_stat.clr_end     = (r_clr == NW'(MAX_NODES - 1));
    assign o_stat.out_busy    = r_ovalid;
    assign o_stat.edge_ok     = (32'(i_in.edge_from) < 32'(i_n)) &&
                                (32'(i_in.edge_to) < 32'(i_n)) &&
                                (32'(r_et) < MAX_EDGES);
    assign o_stat.root_end    = (r_root >= i_n);
    assign o_stat.vis_zero    = (vis_rd == '0);
    assign o_stat.cur_none    = (r_cur == no_edge);
    assign o_stat.j_out       = (CW'(etgt_rd) >= i_n);
    assign o_stat.is_root_scc = (r_lowu == r_visu);
    assign o_stat.scc_more    = (cstk_rd != r_u) && (r_sp != '0);
    assign o_stat.fp_zero     = (r_fp == '0);
    assign o_stat.i_end       = (r_i >= i_n);
    assign o_stat.e_none      = (r_e == no_edge);
    assign o_stat.k_in        = (CW'(etgt_rd) < i_n);
    assign o_stat.cnt_end     = (r_i >= r_comps);

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // memories
    always_ff @(posedge i_clk) begin
        head_rd <= head_mem[head_ra];
        if (op == OP_LDWR) begin
            head_mem[r_a] <= r_et;
        end else if (op == OP_CLR) begin
            head_mem[r_clr] <= no_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        etgt_rd  <= etgt_mem[edge_ra];
        enext_rd <= enext_mem[edge_ra];
        if (op == OP_LDWR) begin
            etgt_mem[r_et[EAW-1:0]]  <= r_b;
            enext_mem[r_et[EAW-1:0]] <= head_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        vis_rd <= vis_mem[vis_ra];
        if (op == OP_ENTER) begin
            vis_mem[r_j] <= clk_next;
        end else if (op == OP_CLR) begin
            vis_mem[r_clr] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        low_rd <= low_mem[fnode_rd];
        if (op == OP_ENTER && r_fp != '0) begin
            low_mem[r_u] <= r_lowu;
        end
    end

    always_ff @(posedge i_clk) begin
        fnode_rd <= fnode_mem[fp_top];
        fcur_rd  <= fcur_mem[fp_top];
        if (op == OP_ENTER && r_fp != '0) begin
            fnode_mem[fp_top] <= r_u;
            fcur_mem[fp_top]  <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        cstk_rd <= cstk_mem[sp_top];
        if (op == OP_ENTER) begin
            cstk_mem[NW'(r_sp)] <= r_j;
        end
    end

    always_ff @(posedge i_clk) begin
        onst_rd <= onst_mem[etgt_rd];
        if (op == OP_ENTER) begin
            onst_mem[r_j] <= 1'b1;
        end else if (op == OP_SCC2) begin
            onst_mem[cstk_rd] <= 1'b0;
        end else if (op == OP_CLR) begin
            onst_mem[r_clr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        comp_rd <= comp_mem[comp_ra];
        if (op == OP_SCC2) begin
            comp_mem[cstk_rd] <= r_comps;
        end
    end

    always_ff @(posedge i_clk) begin
        hasin_rd <= hasin_mem[NW'(r_i)];
        if (op == OP_M4 && comp_rd != r_ci && comp_rd != '0) begin
            hasin_mem[NW'(comp_rd - 1'b1)] <= 1'b1;
        end else if (op == OP_CLR) begin
            hasin_mem[r_clr] <= 1'b0;
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_et     <= '0;
            r_clk    <= '0;
            r_sp     <= '0;
            r_fp     <= '0;
            r_comps  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (op)
                OP_CLR: r_clr <= NW'(r_clr + 1'b1);
                OP_IDLE: begin
                    if (i_cmd.accept) begin
                        r_a    <= NW'(i_in.edge_from);
                        r_b    <= NW'(i_in.edge_to);
                        r_root <= '0;
                        r_i    <= '0;
                        r_src  <= '0;
                        if (i_in.kind == KIND_EDGE && !o_stat.edge_ok) begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                OP_LDWR: r_et <= EW'(r_et + 1'b1);
                OP_ROOT2: begin
                    r_j <= NW'(r_root);
                    if (!o_stat.vis_zero) r_root <= CW'(r_root + 1'b1);
                end
                OP_ENTER: begin
                    r_fp   <= CW'(r_fp + 1'b1);
                    r_sp   <= CW'(r_sp + 1'b1);
                    r_u    <= r_j;
                    r_lowu <= clk_next;
                    r_visu <= clk_next;
                    r_clk  <= clk_next;
                end
                OP_ENTER2: r_cur <= head_rd;
                OP_EDGE: begin
                    r_cur <= enext_rd;
                    r_j   <= etgt_rd;
                end
                OP_EDGE2: begin
                    if (!o_stat.vis_zero && onst_rd && vis_rd < r_lowu) r_lowu <= vis_rd;
                end
                OP_POP: begin
                    r_fp   <= CW'(r_fp - 1'b1);
                    r_lowc <= r_lowu;
                    if (o_stat.is_root_scc) r_comps <= CW'(r_comps + 1'b1);
                end
                OP_SCC1: r_sp <= CW'(r_sp - 1'b1);
                OP_RET1: begin
                    if (o_stat.fp_zero) r_root <= CW'(r_root + 1'b1);
                end
                OP_RET2: begin
                    r_u   <= fnode_rd;
                    r_cur <= fcur_rd;
                end
                OP_RET3: begin
                    r_visu <= vis_rd;
                    r_lowu <= (low_rd < r_lowc) ? low_rd : r_lowc;
                end
                OP_M0: begin
                    if (o_stat.i_end) r_i <= '0;
                end
                OP_M1: begin
                    r_e  <= head_rd;
                    r_ci <= comp_rd;
                end
                OP_M2: begin
                    if (o_stat.e_none) r_i <= CW'(r_i + 1'b1);
                end
                OP_M3: r_e <= enext_rd;
                OP_C1: begin
                    if (!hasin_rd) r_src <= CW'(r_src + 1'b1);
                    r_i <= CW'(r_i + 1'b1);
                end
                OP_DONE: begin
                    // hold until the previous result has left
                    if (!r_ovalid) begin
                        r_out.source_components <= 11'(r_src);
                        r_out.component_count   <= 11'(r_comps);
                        r_out.error             <= r_drop;
                        r_ovalid <= 1'b1;
                        r_clr    <= '0;
                        r_et     <= '0;
                        r_clk    <= '0;
                        r_sp     <= '0;
                        r_fp     <= '0;
                        r_comps  <= '0;
                        r_drop   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/scc_source_component_counter_unit.sv
// top level of the strongly connected component source counter
//
// input channel (valid/ready) carries one transaction per item: kind 0 adds
// a directed edge, kind 1 finishes the graph and starts the search.
// an edge transaction runs through idle, head read and link write; a dropped
// edge (node out of range or edge store full) is taken in idle and sets error.
// a finish runs an iterative tarjan search with an explicit frame stack:
// a root scan over the nodes, node entry, edge scan, return to a parent and
// taking nodes off the component stack, then an incoming-edge marking sweep
// over nodes and edges and a count sweep over the components. all stores are
// single read-port memories. the result leaves through an output register on
// the output channel; after each finish and after reset a clearing pass resets
// the node stores, during which no input is taken.
// while a result waits for the receiver, edges are still taken; a following
// finish holds before loading its result until the waiting one has left.
// a stalled receiver holds the result steady.
// node_count is written through i_cfg_we/i_cfg_wdata and survives finish.
module scc_source_component_counter_unit import scc_pkg::*; #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_NODES + 1);

    logic [10:0]   r_node_count;
    logic [CW-1:0] n_eff;
    t_cmd          cmd;
    t_stat         stat;

    // node count register, reset to one node
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 11'd1;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // counts above capacity act as capacity
    assign n_eff = (32'(r_node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(r_node_count);

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scc_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in_data),
        .i_n         (n_eff),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

>>> verif/scc_checker.sv
// checker for the scc source component counter: predicts each finish result and compares it
module scc_checker import scc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CAP = 1024;
    localparam int EDGE_CAP = 4096;
    localparam int NO_EDGE  = EDGE_CAP;

    logic [10:0] node_count;
    int          adj_head [NODE_CAP];
    int          adj_dst  [EDGE_CAP];
    int          adj_link [EDGE_CAP];
    int          edges_stored;
    logic        dropped;
    t_out        expected_results[$];

    function automatic int nodes_active();
        return (node_count > NODE_CAP) ? NODE_CAP : int'(node_count);
    endfunction

    // iterative tarjan over the stored graph, then count components without incoming edges
    function automatic t_out count_sources();
        int   n, nf, sd, tick, found, r, u, i, j, p, y, e, k, srcs;
        int   disc [NODE_CAP];
        int   low  [NODE_CAP];
        int   stk  [NODE_CAP];
        int   comp [NODE_CAP];
        int   fr_node [NODE_CAP];
        int   fr_cur  [NODE_CAP];
        bit   on_stk  [NODE_CAP];
        bit   incoming [NODE_CAP];
        t_out res;
        n = nodes_active();
        sd = 0;
        tick = 0;
        found = 0;
        for (r = 0; r < NODE_CAP; r++) begin
            disc[r] = 0;
            on_stk[r] = 0;
            incoming[r] = 0;
            comp[r] = 0;
        end
        for (r = 0; r < n; r++) begin
            if (disc[r] == 0) begin
                nf = 0;
                tick++;
                disc[r] = tick;
                low[r] = tick;
                stk[sd++] = r;
                on_stk[r] = 1;
                fr_node[nf] = r;
                fr_cur[nf] = adj_head[r];
                nf++;
                while (nf > 0) begin
                    u = fr_node[nf-1];
                    if (fr_cur[nf-1] < NO_EDGE) begin
                        i = fr_cur[nf-1];
                        j = adj_dst[i];
                        fr_cur[nf-1] = adj_link[i];
                        if (j < n) begin
                            if (disc[j] == 0) begin
                                tick++;
                                disc[j] = tick;
                                low[j] = tick;
                                stk[sd++] = j;
                                on_stk[j] = 1;
                                fr_node[nf] = j;
                                fr_cur[nf] = adj_head[j];
                                nf++;
                            end else if (on_stk[j] && disc[j] < low[u]) begin
                                low[u] = disc[j];
                            end
                        end
                    end else begin
                        nf--;
                        if (low[u] == disc[u]) begin
                            found++;
                            do begin
                                sd--;
                                y = stk[sd];
                                on_stk[y] = 0;
                                comp[y] = found;
                            end while (y != u && sd > 0);
                        end
                        if (nf > 0) begin
                            p = fr_node[nf-1];
                            if (low[u] < low[p]) low[p] = low[u];
                        end
                    end
                end
            end
        end
        for (i = 0; i < n; i++) begin
            for (e = adj_head[i]; e < NO_EDGE; e = adj_link[e]) begin
                k = adj_dst[e];
                if (k < n && comp[i] != comp[k] && comp[k] >= 1)
                    incoming[(comp[k] - 1) % NODE_CAP] = 1;
            end
        end
        srcs = 0;
        for (i = 0; i < found && i < NODE_CAP; i++)
            if (!incoming[i]) srcs++;
        res.source_components = srcs[10:0];
        res.component_count   = found[10:0];
        res.error             = dropped;
        return res;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < NODE_CAP; i++) adj_head[i] = NO_EDGE;
        edges_stored = 0;
        dropped = 0;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        int   a, b;
        if (!i_rst_n) begin
            node_count <= 11'd1;
            o_fail_count = 0;
            clear_graph();
            expected_results.delete();
        end else begin
            if (i_cfg_we) node_count <= i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_EDGE) begin
                    a = i_in_data.edge_from;
                    b = i_in_data.edge_to;
                    if (a >= nodes_active() || b >= nodes_active() ||
                        edges_stored >= EDGE_CAP) begin
                        dropped = 1;
                    end else begin
                        adj_dst[edges_stored] = b;
                        adj_link[edges_stored] = adj_head[a];
                        adj_head[a] = edges_stored;
                        edges_stored++;
                    end
                end else begin
                    expected_results.push_back(count_sources());
                    clear_graph();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result transaction: %p", i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.source_components !== want.source_components ||
                        i_out_data.component_count !== want.component_count ||
                        i_out_data.error !== want.error) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"result mismatch: expected src=%0d cnt=%0d err=%0d, ",
                                      "got src=%0d cnt=%0d err=%0d"},
                                     want.source_components, want.component_count, want.error,
                                     i_out_data.source_components, i_out_data.component_count,
                                     i_out_data.error);
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule

>>> verif/tb.sv
// testbench top for the scc source component counter: stimulus and verdict
module tb;
    import scc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // settle time after the last result: covers the clearing pass
    localparam int SETTLE = 1200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic [10:0] cfg_wdata;
    int          fail_count;
    int          pending;
    bit          burst;   // no idling while set
    int          item_total;

    scc_source_component_counter_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    scc_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // per-transaction idle gap, zero during a burst stretch
    function automatic int draw_gap();
        if (burst) return 0;
        return $urandom_range(0, 17);
    endfunction

    // one input transaction, held until accepted
    task automatic send_item(input logic kind, input int src, input int dst);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.kind <= kind;
        in_data.edge_from <= src[9:0];
        in_data.edge_to <= dst[9:0];
        do @(posedge clk); while (!in_ready);
        item_total++;
        if ($urandom_range(0, 40) == 0) burst = ~burst;
    endtask

    task automatic add_edge(input int src, input int dst);
        send_item(KIND_EDGE, src, dst);
    endtask

    task automatic finish_graph();
        send_item(KIND_FINISH, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // drop valid, let every expected result drain, then give the block its clearing time
    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // node_count written only with the block idle
    task automatic set_nodes(input int value);
        go_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver side: random stalls with burst stretches
    initial begin
        int gap;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            gap = draw_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog: far above the slowest legal run
    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int n, ne, lim, src, dst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        burst = 1'b0;
        item_total = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        // wait out the clearing pass after reset
        do @(posedge clk); while (!in_ready);

        // reset node count of one: empty graph, then a self loop
        finish_graph();
        add_edge(0, 0);
        finish_graph();
        // no nodes at all: every edge dropped, nothing found
        set_nodes(0);
        add_edge(0, 0);
        finish_graph();
        // node count above capacity acts as full size; field extremes
        set_nodes(2047);
        add_edge(1023, 0);
        add_edge(0, 1023);
        add_edge(5, 5);
        finish_graph();
        // a cycle with a tail, an out of range edge, then the count lowered
        set_nodes(4);
        add_edge(0, 1);
        add_edge(1, 2);
        add_edge(2, 0);
        add_edge(2, 3);
        add_edge(4, 0);
        add_edge(3, 1);
        set_nodes(3);
        finish_graph();

        // random graphs, mostly small and dense so components form
        while (item_total < 750) begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 1024);
                1:       n = $urandom_range(1025, 2047);
                default: n = $urandom_range(1, 24);
            endcase
            set_nodes(n);
            lim = (n > 1024) ? 1024 : n;
            ne = $urandom_range(0, 40);
            for (int i = 0; i < ne; i++) begin
                if (lim == 0 || $urandom_range(0, 19) == 0) begin
                    // noise: any node number
                    src = $urandom_range(0, 1023);
                    dst = $urandom_range(0, 1023);
                end else begin
                    src = $urandom_range(0, lim - 1);
                    dst = $urandom_range(0, lim - 1);
                end
                add_edge(src, dst);
            end
            // now and then shrink the node count over a loaded graph
            if (lim > 1 && $urandom_range(0, 7) == 0)
                set_nodes($urandom_range(0, lim - 1));
            finish_graph();
        end

        go_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/scc_pkg.sv
rtl/scc_ctrl.sv
rtl/scc_dp.sv
rtl/scc_source_component_counter_unit.sv
verif/scc_checker.sv
verif/tb.sv
